// File: design/go_to_goal_heading_controller_defines.svh
// Shared assertion macros for the go-to-goal heading controller.
`ifndef GO_TO_GOAL_HEADING_CONTROLLER_DEFINES_SVH
`define GO_TO_GOAL_HEADING_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define GTG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define GTG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/gtg_pkg.sv
`default_nettype none

package gtg_pkg;

    // Field widths
    localparam int POS_W   = 32;
    localparam int DIFF_W  = 33;   // exact goal minus pose
    localparam int ANG_W   = 16;   // Q2.13 angle
    localparam int TOL_W   = 15;
    localparam int ARR_W   = 16;
    localparam int SPD_W   = 16;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 32;

    // Normalizer: scale until the larger magnitude reaches 2^40
    localparam int MAG_W      = 41;
    localparam int VEC_W      = MAG_W + 1;
    localparam int NORM_CELLS = 6;     // shifts 32,16,8,4,2,1

    // Rotation datapath
    localparam int CX_W    = VEC_W + 3;
    localparam int Z_W     = 28;       // Q.24 radians
    localparam int RND_SH  = 11;       // Q.24 -> Q.13
    localparam int Q_W     = Z_W - RND_SH;
    localparam int ERR_W   = 18;

    localparam int ATAN_ENTRIES           = 24;
    localparam int ANGLE_ITERATIONS_DEF   = 16;

    localparam logic signed [ANG_W-1:0] PI_Q13      = 16'sd25736;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 16'sd12868;
    localparam logic signed [Z_W-1:0]   HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [Z_W-1:0]   RND_BIAS    = 28'sd1024;
    localparam logic [17:0]             TWO_PI_Q13  = 18'd51472;

    // atan(2^-i) in Q.24, rounded to nearest
    localparam logic [23:0] ATAN_Q24 [ATAN_ENTRIES] = '{
        24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
        24'd1047214,  24'd524117,  24'd262123,  24'd131069,
        24'd65536,    24'd32768,   24'd16384,   24'd8192,
        24'd4096,     24'd2048,    24'd1024,    24'd512,
        24'd256,      24'd128,     24'd64,      24'd32,
        24'd16,       24'd8,       24'd4,       24'd2
    };

    // Register reset values
    localparam logic [TOL_W-1:0] HEAD_TOL_RST = 15'd819;
    localparam logic [ARR_W-1:0] ARR_TOL_RST  = 16'd6554;
    localparam logic [SPD_W-1:0] FWD_SPD_RST  = 16'd32768;
    localparam logic [SPD_W-1:0] TURN_SPD_RST = 16'd32768;

    typedef enum logic [IDX_W-1:0] {
        REG_GOAL_X     = 3'd0,
        REG_GOAL_Y     = 3'd1,
        REG_GOAL_VALID = 3'd2,
        REG_HEAD_TOL   = 3'd3,
        REG_ARR_TOL    = 3'd4,
        REG_FWD_SPEED  = 3'd5,
        REG_TURN_SPEED = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_STOP = 2'd0,
        MODE_FWD  = 2'd1,
        MODE_TURN = 2'd2
    } t_mode;

    // Data that rides alongside the angle datapath
    typedef struct packed {
        logic signed [ANG_W-1:0] heading;
        logic                    arrive;
        logic                    special;
        logic signed [ANG_W-1:0] spec_br;
    } t_side;

    typedef struct packed {
        logic signed [VEC_W-1:0] dx;
        logic signed [VEC_W-1:0] dy;
        logic [MAG_W-1:0]        m;
    } t_vec;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_rot;

    typedef struct packed {
        t_mode                   mode;
        logic [SPD_W-1:0]        lin;
        logic [SPD_W-1:0]        ang;
        logic signed [ANG_W-1:0] herr;
    } t_cmd;

endpackage

`default_nettype wire

// File: design/gtg_ifs.sv
`default_nettype none

// Pose channel
interface gtg_pose_if;
    import gtg_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [ANG_W-1:0] heading;
    modport source (output valid, pos_x, pos_y, heading, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

// Drive command channel
interface gtg_cmd_if;
    import gtg_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              drive_mode;
    logic [SPD_W-1:0]        linear_speed;
    logic [SPD_W-1:0]        angular_speed;
    logic signed [ANG_W-1:0] heading_error;
    modport source (output valid, drive_mode, linear_speed, angular_speed,
                    heading_error, input ready);
    modport sink   (input valid, drive_mode, linear_speed, angular_speed,
                    heading_error, output ready);
endinterface

// Register write channel
interface gtg_cfg_if;
    import gtg_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/go_to_goal_heading_controller.sv
// Channel   Dir  Modport  Payload
// i_pose    in   sink     pos_x, pos_y (Q15.16), heading (Q2.13)
// o_cmd     out  source   drive_mode, linear_speed, angular_speed, heading_error
// i_cfg     in   sink     index (3 bits), data (32 bits); always ready
//
// One pose per cycle while the skid slot is empty. A pose beat passes ANGLE_ITERATIONS + 12
// register stages before its command is valid on o_cmd: three difference/magnitude
// stages, six normalizer cells, one quadrant stage, one CORDIC cell per iteration,
// a rounding stage and the output register. Reset is synchronous, active low, and
// clears every valid flag and returns the configuration registers to their reset
// values. A stalled o_cmd fills a one-beat skid slot; the whole chain then holds and
// i_pose.ready drops until the skid slot drains.
`default_nettype none

`include "go_to_goal_heading_controller_defines.svh"

module go_to_goal_heading_controller #(
    parameter int ANGLE_ITERATIONS = gtg_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gtg_pose_if.sink  i_pose,
    gtg_cmd_if.source o_cmd,
    gtg_cfg_if.sink   i_cfg
);
    import gtg_pkg::*;

    // ---------------------------------------------------------------------
    // Configuration registers
    logic signed [POS_W-1:0] r_goal_x;
    logic signed [POS_W-1:0] r_goal_y;
    logic                    r_goal_valid;
    logic [TOL_W-1:0]        r_head_tol;
    logic [ARR_W-1:0]        r_arr_tol;
    logic [SPD_W-1:0]        r_fwd_speed;
    logic [SPD_W-1:0]        r_turn_speed;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x     <= '0;
            r_goal_y     <= '0;
            r_goal_valid <= 1'b0;
            r_head_tol   <= HEAD_TOL_RST;
            r_arr_tol    <= ARR_TOL_RST;
            r_fwd_speed  <= FWD_SPD_RST;
            r_turn_speed <= TURN_SPD_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_GOAL_X:     r_goal_x     <= i_cfg.data;
                REG_GOAL_Y:     r_goal_y     <= i_cfg.data;
                REG_GOAL_VALID: r_goal_valid <= i_cfg.data[0];
                REG_HEAD_TOL:   r_head_tol   <= i_cfg.data[TOL_W-1:0];
                REG_ARR_TOL:    r_arr_tol    <= i_cfg.data[ARR_W-1:0];
                REG_FWD_SPEED:  r_fwd_speed  <= i_cfg.data[SPD_W-1:0];
                REG_TURN_SPEED: r_turn_speed <= i_cfg.data[SPD_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Chain advance: holds only while the skid slot is occupied
    logic r_skid_valid;
    logic w_adv;
    logic w_accept;

    assign w_adv        = !r_skid_valid;
    assign i_pose.ready = w_adv;
    assign w_accept     = i_pose.valid && w_adv;

    // ---------------------------------------------------------------------
    // Stage 1: position error (no beat enters the chain without a goal)
    logic                     r_s1_valid;
    logic signed [DIFF_W-1:0] r_s1_dx;
    logic signed [DIFF_W-1:0] r_s1_dy;
    logic signed [ANG_W-1:0]  r_s1_hd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_accept && r_goal_valid;
            r_s1_dx    <= DIFF_W'(r_goal_x) - DIFF_W'(i_pose.pos_x);
            r_s1_dy    <= DIFF_W'(r_goal_y) - DIFF_W'(i_pose.pos_y);
            r_s1_hd    <= i_pose.heading;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: magnitudes, arrival test, axis-aligned bearings
    logic [DIFF_W-1:0] w_ax;
    logic [DIFF_W-1:0] w_ay;
    t_side             n_s2_side;

    assign w_ax = r_s1_dx[DIFF_W-1] ? DIFF_W'(-r_s1_dx) : DIFF_W'(r_s1_dx);
    assign w_ay = r_s1_dy[DIFF_W-1] ? DIFF_W'(-r_s1_dy) : DIFF_W'(r_s1_dy);

    always_comb begin
        n_s2_side.heading = r_s1_hd;
        n_s2_side.arrive  = (w_ax < DIFF_W'(r_arr_tol)) && (w_ay < DIFF_W'(r_arr_tol));
        n_s2_side.special = (r_s1_dy == '0) || (r_s1_dx == '0);
        if (r_s1_dy == '0) begin
            n_s2_side.spec_br = (r_s1_dx <= 0) ? PI_Q13 : '0;
        end else begin
            n_s2_side.spec_br = (r_s1_dy > 0) ? HALF_PI_Q13 : -HALF_PI_Q13;
        end
    end

    logic                     r_s2_valid;
    logic signed [DIFF_W-1:0] r_s2_dx;
    logic signed [DIFF_W-1:0] r_s2_dy;
    logic [DIFF_W-1:0]        r_s2_ax;
    logic [DIFF_W-1:0]        r_s2_ay;
    t_side                    r_s2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
            r_s2_dx    <= r_s1_dx;
            r_s2_dy    <= r_s1_dy;
            r_s2_ax    <= w_ax;
            r_s2_ay    <= w_ay;
            r_s2_side  <= n_s2_side;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: larger magnitude, widen for the normalizer
    logic  r_s3_valid;
    t_vec  r_s3_vec;
    t_side r_s3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s3_valid  <= r_s2_valid;
            r_s3_vec.dx <= VEC_W'(r_s2_dx);
            r_s3_vec.dy <= VEC_W'(r_s2_dy);
            r_s3_vec.m  <= MAG_W'((r_s2_ax > r_s2_ay) ? r_s2_ax : r_s2_ay);
            r_s3_side   <= r_s2_side;
        end
    end

    // ---------------------------------------------------------------------
    // Normalizer chain
    logic  w_nv    [NORM_CELLS+1];
    t_vec  w_nvec  [NORM_CELLS+1];
    t_side w_nside [NORM_CELLS+1];

    assign w_nv[0]    = r_s3_valid;
    assign w_nvec[0]  = r_s3_vec;
    assign w_nside[0] = r_s3_side;

    for (genvar k = 0; k < NORM_CELLS; k++) begin : g_norm
        gtg_norm_cell #(
            .SHIFT (1 << (NORM_CELLS - 1 - k))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_nv[k]),
            .i_vec   (w_nvec[k]),
            .i_side  (w_nside[k]),
            .o_valid (w_nv[k+1]),
            .o_vec   (w_nvec[k+1]),
            .o_side  (w_nside[k+1])
        );
    end

    // ---------------------------------------------------------------------
    // Quadrant stage: fold left half-plane into the right by +-pi/2
    logic signed [CX_W-1:0] w_qdx;
    logic signed [CX_W-1:0] w_qdy;
    t_rot                   n_q_rot;

    assign w_qdx = CX_W'(w_nvec[NORM_CELLS].dx);
    assign w_qdy = CX_W'(w_nvec[NORM_CELLS].dy);

    always_comb begin
        if (w_qdx < 0) begin
            if (w_qdy > 0) begin
                n_q_rot.x = w_qdy;
                n_q_rot.y = -w_qdx;
                n_q_rot.z = HALF_PI_Q24;
            end else begin
                n_q_rot.x = -w_qdy;
                n_q_rot.y = w_qdx;
                n_q_rot.z = -HALF_PI_Q24;
            end
        end else begin
            n_q_rot.x = w_qdx;
            n_q_rot.y = w_qdy;
            n_q_rot.z = '0;
        end
    end

    logic  r_q_valid;
    t_rot  r_q_rot;
    t_side r_q_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (w_adv) begin
            r_q_valid <= w_nv[NORM_CELLS];
            r_q_rot   <= n_q_rot;
            r_q_side  <= w_nside[NORM_CELLS];
        end
    end

    // ---------------------------------------------------------------------
    // CORDIC chain
    logic  w_cv    [ANGLE_ITERATIONS+1];
    t_rot  w_crot  [ANGLE_ITERATIONS+1];
    t_side w_cside [ANGLE_ITERATIONS+1];

    assign w_cv[0]    = r_q_valid;
    assign w_crot[0]  = r_q_rot;
    assign w_cside[0] = r_q_side;

    for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cordic
        gtg_cordic_cell #(
            .IDX (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_cv[i]),
            .i_rot   (w_crot[i]),
            .i_side  (w_cside[i]),
            .o_valid (w_cv[i+1]),
            .o_rot   (w_crot[i+1]),
            .o_side  (w_cside[i+1])
        );
    end

    // ---------------------------------------------------------------------
    // Rounding stage: Q.24 -> Q2.13, wrap once into (-pi, pi]
    logic signed [Z_W-1:0] w_zr;
    logic signed [Q_W-1:0] w_q;
    logic signed [Q_W-1:0] n_br;

    assign w_zr = w_crot[ANGLE_ITERATIONS].z + RND_BIAS;
    assign w_q  = w_zr[Z_W-1:RND_SH];

    always_comb begin
        if (w_cside[ANGLE_ITERATIONS].special) begin
            n_br = Q_W'(w_cside[ANGLE_ITERATIONS].spec_br);
        end else if (w_q > Q_W'(PI_Q13)) begin
            n_br = w_q - Q_W'(TWO_PI_Q13);
        end else if (w_q <= -Q_W'(PI_Q13)) begin
            n_br = w_q + Q_W'(TWO_PI_Q13);
        end else begin
            n_br = w_q;
        end
    end

    logic                  r_r_valid;
    logic signed [Q_W-1:0] r_r_br;
    t_side                 r_r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (w_adv) begin
            r_r_valid <= w_cv[ANGLE_ITERATIONS];
            r_r_br    <= n_br;
            r_r_side  <= w_cside[ANGLE_ITERATIONS];
        end
    end

    // ---------------------------------------------------------------------
    // Heading error and command select
    logic signed [ERR_W-1:0] w_err_raw;
    logic signed [ERR_W-1:0] w_err;
    logic [ERR_W-1:0]        w_err_mag;
    t_cmd                    n_cmd;

    assign w_err_raw = ERR_W'(r_r_br) - ERR_W'(r_r_side.heading);

    always_comb begin
        if (w_err_raw > ERR_W'(PI_Q13)) begin
            w_err = w_err_raw - $signed(TWO_PI_Q13);
        end else if (w_err_raw <= -ERR_W'(PI_Q13)) begin
            w_err = w_err_raw + $signed(TWO_PI_Q13);
        end else begin
            w_err = w_err_raw;
        end
    end

    assign w_err_mag = w_err[ERR_W-1] ? ERR_W'(-w_err) : ERR_W'(w_err);

    always_comb begin
        n_cmd.herr = w_err[ANG_W-1:0];
        if (r_r_side.arrive) begin
            n_cmd.mode = MODE_STOP;
            n_cmd.lin  = '0;
            n_cmd.ang  = '0;
        end else if (w_err_mag < ERR_W'(r_head_tol)) begin
            n_cmd.mode = MODE_FWD;
            n_cmd.lin  = r_fwd_speed;
            n_cmd.ang  = '0;
        end else begin
            n_cmd.mode = MODE_TURN;
            n_cmd.lin  = '0;
            n_cmd.ang  = r_turn_speed;
        end
    end

    // ---------------------------------------------------------------------
    // Output register with one-beat skid slot
    logic w_take;
    logic w_in_beat;
    logic r_out_valid;
    t_cmd r_out;
    t_cmd r_skid;

    assign w_take    = r_out_valid && o_cmd.ready;
    assign w_in_beat = w_adv && r_r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || w_take) begin
            r_out_valid <= w_in_beat;
            r_out       <= n_cmd;
        end else if (w_in_beat) begin
            r_skid_valid <= 1'b1;
            r_skid       <= n_cmd;
        end
    end

    assign o_cmd.valid         = r_out_valid;
    assign o_cmd.drive_mode    = r_out.mode;
    assign o_cmd.linear_speed  = r_out.lin;
    assign o_cmd.angular_speed = r_out.ang;
    assign o_cmd.heading_error = r_out.herr;

    // ---------------------------------------------------------------------
    // Assertions
    `GTG_ASSERT_IMP(a_stop_zero_speed, i_clk, i_rst_n,
        o_cmd.valid && (o_cmd.drive_mode == MODE_STOP),
        (o_cmd.linear_speed == '0) && (o_cmd.angular_speed == '0),
        "stop command carries a nonzero speed")
    `GTG_ASSERT_IMP(a_err_wrapped, i_clk, i_rst_n,
        o_cmd.valid,
        (o_cmd.heading_error <= PI_Q13) && (o_cmd.heading_error > -PI_Q13),
        "heading error outside (-pi, pi]")
    `GTG_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n,
        r_skid_valid, r_out_valid,
        "skid slot full while output register empty")
    `GTG_ASSERT_NXT(a_skid_holds, i_clk, i_rst_n,
        r_skid_valid && !o_cmd.ready, r_skid_valid && !i_pose.ready,
        "skid slot lost a beat or chain resumed under stall")

endmodule

`default_nettype wire

// File: design/gtg_norm_cell.sv
`default_nettype none

// One step of the normalizing shift: shift by SHIFT if the magnitude stays
// below 2^MAG_W afterward.
module gtg_norm_cell #(
    parameter int SHIFT = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  gtg_pkg::t_vec  i_vec,
    input  gtg_pkg::t_side i_side,
    output logic           o_valid,
    output gtg_pkg::t_vec  o_vec,
    output gtg_pkg::t_side o_side
);
    import gtg_pkg::*;

    logic fits;
    t_vec n_vec;
    logic r_valid;
    t_vec r_vec;
    t_side r_side;

    // Top SHIFT bits clear: room to shift
    assign fits = (i_vec.m[MAG_W-1 -: SHIFT] == '0);

    always_comb begin
        n_vec = i_vec;
        if (fits) begin
            n_vec.dx = i_vec.dx <<< SHIFT;
            n_vec.dy = i_vec.dy <<< SHIFT;
            n_vec.m  = i_vec.m << SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
            r_vec   <= n_vec;
            r_side  <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// File: design/gtg_cordic_cell.sv
`default_nettype none

// One vectoring micro-rotation, step IDX: drives y toward zero and
// accumulates the angle.
module gtg_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  gtg_pkg::t_rot  i_rot,
    input  gtg_pkg::t_side i_side,
    output logic           o_valid,
    output gtg_pkg::t_rot  o_rot,
    output gtg_pkg::t_side o_side
);
    import gtg_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN_STEP = Z_W'(ATAN_Q24[IDX]);

    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic signed [CX_W-1:0] xs;
    logic signed [CX_W-1:0] ys;
    t_rot  n_rot;
    logic  r_valid;
    t_rot  r_rot;
    t_side r_side;

    assign x  = i_rot.x;
    assign y  = i_rot.y;
    assign z  = i_rot.z;
    assign xs = x >>> IDX;
    assign ys = y >>> IDX;

    // Rotate by -atan when y is positive, else by +atan
    always_comb begin
        if (y > 0) begin
            n_rot.x = x + ys;
            n_rot.y = y - xs;
            n_rot.z = z + ATAN_STEP;
        end else begin
            n_rot.x = x - ys;
            n_rot.y = y + xs;
            n_rot.z = z - ATAN_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
            r_rot   <= n_rot;
            r_side  <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rot   = r_rot;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// File: verif/tb_go_to_goal_heading_controller.sv
`timescale 1ns / 100ps

module tb_go_to_goal_heading_controller;
    import gtg_pkg::*;

    localparam int CORDIC_STEPS = ANGLE_ITERATIONS_DEF;
    localparam int PIPE_DEPTH   = CORDIC_STEPS + 13;
    localparam int DRAIN_CYCLES = PIPE_DEPTH + 8;
    localparam int STALL_CYCLES = 200;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_POSES  = 85;
    localparam int REPORT_LIMIT = 10;
    localparam longint TIMEOUT_NS = 2_000_000;

    localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;   // no register behind this index

    localparam longint PI_L        = longint'(PI_Q13);
    localparam longint HALF_PI_L   = longint'(HALF_PI_Q13);
    localparam longint TWO_PI_L    = longint'(TWO_PI_Q13);
    localparam longint HALF_PI_Z_L = longint'(HALF_PI_Q24);
    localparam longint NORM_TARGET = 64'sd1 <<< 40;

    typedef enum logic [1:0] {
        CHK_MODEL,   // expectation from the predictor
        CHK_NONE,    // beat must produce no command
        CHK_TYPED    // expectation written into the script
    } t_check_kind;

    typedef enum logic {
        ROW_REG,
        ROW_POSE
    } t_row_kind;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [ANG_W-1:0] heading;
    } t_pose;

    typedef struct packed {
        t_row_kind         kind;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] data;
        t_pose             pose;
        t_check_kind       chk;
        t_cmd              cmd;
    } t_script_row;

    logic i_clk;
    logic i_rst_n;

    gtg_pose_if pose_if ();
    gtg_cmd_if  cmd_if ();
    gtg_cfg_if  cfg_if ();

    go_to_goal_heading_controller #(
        .ANGLE_ITERATIONS(CORDIC_STEPS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pose (pose_if),
        .o_cmd  (cmd_if),
        .i_cfg  (cfg_if)
    );

    // Register mirror, updated on every accepted write beat
    logic signed [POS_W-1:0] goal_x_q;
    logic signed [POS_W-1:0] goal_y_q;
    logic                    goal_valid_q;
    logic [TOL_W-1:0]        head_tol_q;
    logic [ARR_W-1:0]        arr_tol_q;
    logic [SPD_W-1:0]        fwd_speed_q;
    logic [SPD_W-1:0]        turn_speed_q;

    // Sideband that travels with each pose beat
    t_check_kind beat_check;
    t_cmd        beat_typed;

    t_cmd pending_commands[$];

    int send_idle_pct  = 22;
    int recv_idle_pct  = 60;
    int stall_requests = 0;
    int stalls_started = 0;
    int stall_left     = 0;

    int error_count      = 0;
    int report_count     = 0;
    int poses_accepted   = 0;
    int commands_checked = 0;
    int register_writes  = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #(TIMEOUT_NS);
        $display("go_to_goal_heading_controller regression: fail");
        $finish;
    end

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Bearing of (dx, dy) in Q2.13, CORDIC vectoring on a normalized vector
    function automatic longint goal_bearing_q13(longint dx, longint dy);
        longint x, y, z, m, q, xs, ys;
        if (dy == 0) return (dx <= 0) ? PI_L : 0;
        if (dx == 0) return (dy > 0) ? HALF_PI_L : -HALF_PI_L;
        m = (magnitude(dx) > magnitude(dy)) ? magnitude(dx) : magnitude(dy);
        while (m < NORM_TARGET) begin
            dx = dx * 2;
            dy = dy * 2;
            m  = m * 2;
        end
        // fold left half-plane into the right one
        z = 0;
        if (dx < 0) begin
            if (dy > 0) begin
                x = dy;  y = -dx; z = HALF_PI_Z_L;
            end else begin
                x = -dy; y = dx;  z = -HALF_PI_Z_L;
            end
        end else begin
            x = dx; y = dy;
        end
        for (int i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + longint'(ATAN_Q24[i]);
            end else begin
                x = x - ys; y = y + xs; z = z - longint'(ATAN_Q24[i]);
            end
        end
        q = (z + 1024) >>> RND_SH;
        if (q > PI_L) q = q - TWO_PI_L;
        else if (q <= -PI_L) q = q + TWO_PI_L;
        return q;
    endfunction

    function automatic t_cmd predict_drive_command(t_pose p);
        longint dx, dy, err;
        t_cmd   c;
        dx  = longint'(goal_x_q) - longint'(p.pos_x);
        dy  = longint'(goal_y_q) - longint'(p.pos_y);
        err = goal_bearing_q13(dx, dy) - longint'(p.heading);
        if (err > PI_L) err = err - TWO_PI_L;
        else if (err <= -PI_L) err = err + TWO_PI_L;
        c.herr = err[ANG_W-1:0];
        if (magnitude(dx) < longint'(arr_tol_q) && magnitude(dy) < longint'(arr_tol_q)) begin
            c.mode = MODE_STOP; c.lin = '0;          c.ang = '0;
        end else if (magnitude(err) < longint'(head_tol_q)) begin
            c.mode = MODE_FWD;  c.lin = fwd_speed_q; c.ang = '0;
        end else begin
            c.mode = MODE_TURN; c.lin = '0;          c.ang = turn_speed_q;
        end
        return c;
    endfunction

    // Mostly poses around the goal with a heading aimed near the bearing
    function automatic t_pose random_pose();
        t_pose  p;
        longint span, dx, dy, aim, band;
        int     spread;
        p.pos_x   = $urandom;
        p.pos_y   = $urandom;
        p.heading = ANG_W'($urandom);
        if ($urandom_range(99) >= 15) begin
            case ($urandom_range(3))
                0:       span = 2 * longint'(arr_tol_q) + 2;
                1:       span = 64'sd1 <<< 16;
                2:       span = 64'sd1 <<< 20;
                default: span = 64'sd1 <<< 31;
            endcase
            dx = (longint'($urandom) % (2 * span + 1)) - span;
            dy = (longint'($urandom) % (2 * span + 1)) - span;
            case ($urandom_range(9))
                0:       dx = 0;
                1:       dy = 0;
                default: ;
            endcase
            p.pos_x = goal_x_q - dx[POS_W-1:0];
            p.pos_y = goal_y_q - dy[POS_W-1:0];
        end
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
                band = 2 * longint'(head_tol_q) + 3;
                aim  = goal_bearing_q13(longint'(goal_x_q) - longint'(p.pos_x),
                                        longint'(goal_y_q) - longint'(p.pos_y));
                aim  = aim + (longint'($urandom) % (2 * band + 1)) - band;
                p.heading = aim[ANG_W-1:0];
            end
            6, 7, 8: begin
                spread    = $urandom_range(0, 2 * int'(PI_Q13));
                p.heading = ANG_W'(spread - int'(PI_Q13));
            end
            default: ;   // full 16-bit heading, out-of-range values included
        endcase
        return p;
    endfunction

    function automatic t_script_row reg_row(logic [IDX_W-1:0] index, logic [DATA_W-1:0] data);
        t_script_row r;
        r       = '0;
        r.kind  = ROW_REG;
        r.index = index;
        r.data  = data;
        return r;
    endfunction

    function automatic t_script_row pose_row(logic signed [POS_W-1:0] px,
                                             logic signed [POS_W-1:0] py,
                                             logic signed [ANG_W-1:0] hd,
                                             t_check_kind chk, t_mode mode,
                                             logic [SPD_W-1:0] lin, logic [SPD_W-1:0] ang,
                                             logic signed [ANG_W-1:0] herr);
        t_script_row r;
        r              = '0;
        r.kind         = ROW_POSE;
        r.pose.pos_x   = px;
        r.pose.pos_y   = py;
        r.pose.heading = hd;
        r.chk          = chk;
        r.cmd.mode     = mode;
        r.cmd.lin      = lin;
        r.cmd.ang      = ang;
        r.cmd.herr     = herr;
        return r;
    endfunction

    // Offer one pose beat, with random gaps before it
    task automatic offer_pose(t_pose p, t_check_kind chk, t_cmd typed);
        while ($urandom_range(99) < send_idle_pct) begin
            pose_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pose_if.valid   <= 1'b1;
        pose_if.pos_x   <= p.pos_x;
        pose_if.pos_y   <= p.pos_y;
        pose_if.heading <= p.heading;
        beat_check      <= chk;
        beat_typed      <= typed;
        @(posedge i_clk);
        while (!pose_if.ready) @(posedge i_clk);
    endtask

    // Stop offering, let every command come out and the pipe run empty
    task automatic settle_pipeline();
        pose_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_commands.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [IDX_W-1:0] index, logic [DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Per-phase settings: random, all-minimum, all-maximum; odd phases add upper-bit noise
    task automatic load_phase_settings(int phase);
        logic [DATA_W-1:0] gx, gy, noise;
        logic [TOL_W-1:0]  ht;
        logic [ARR_W-1:0]  at;
        logic [SPD_W-1:0]  fs, ts;
        case (phase % 4)
            1: begin
                gx = 32'h8000_0000; gy = 32'h7FFF_FFFF;
                ht = '0; at = '0; fs = '0; ts = '0;
            end
            2: begin
                gx = 32'h7FFF_FFFF; gy = 32'h8000_0000;
                ht = '1; at = '1; fs = '1; ts = '1;
            end
            default: begin
                gx = $urandom;
                gy = $urandom;
                ht = TOL_W'($urandom_range(0, 25736));
                at = ARR_W'($urandom);
                fs = SPD_W'($urandom);
                ts = SPD_W'($urandom);
            end
        endcase
        noise = (phase % 2 == 1) ? $urandom : 32'd0;
        settle_pipeline();
        write_register(REG_GOAL_X, gx);
        write_register(REG_GOAL_Y, gy);
        write_register(REG_HEAD_TOL, {noise[DATA_W-1:TOL_W], ht});
        write_register(REG_ARR_TOL, {noise[DATA_W-1:ARR_W], at});
        write_register(REG_FWD_SPEED, {noise[DATA_W-1:SPD_W], fs});
        write_register(REG_TURN_SPEED, {noise[DATA_W-1:SPD_W], ts});
        write_register(REG_SPARE, $urandom);
        write_register(REG_GOAL_VALID, {noise[DATA_W-1:1], 1'b1});
    endtask

    // Command receiver: random back-pressure, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            cmd_if.ready <= 1'b0;
        end else if (stalls_started != stall_requests) begin
            stalls_started = stalls_started + 1;
            stall_left     = STALL_CYCLES;
            cmd_if.ready <= 1'b0;
        end else begin
            cmd_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Beat monitor: register mirror, expectation store and command check
    always @(posedge i_clk) begin : beat_monitor
        t_pose seen;
        t_cmd  want;
        if (!i_rst_n) begin
            goal_x_q     = '0;
            goal_y_q     = '0;
            goal_valid_q = 1'b0;
            head_tol_q   = HEAD_TOL_RST;
            arr_tol_q    = ARR_TOL_RST;
            fwd_speed_q  = FWD_SPD_RST;
            turn_speed_q = TURN_SPD_RST;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                register_writes++;
                case (cfg_if.index)
                    REG_GOAL_X:     goal_x_q     = cfg_if.data;
                    REG_GOAL_Y:     goal_y_q     = cfg_if.data;
                    REG_GOAL_VALID: goal_valid_q = cfg_if.data[0];
                    REG_HEAD_TOL:   head_tol_q   = cfg_if.data[TOL_W-1:0];
                    REG_ARR_TOL:    arr_tol_q    = cfg_if.data[ARR_W-1:0];
                    REG_FWD_SPEED:  fwd_speed_q  = cfg_if.data[SPD_W-1:0];
                    REG_TURN_SPEED: turn_speed_q = cfg_if.data[SPD_W-1:0];
                    default: ;
                endcase
            end
            // check before queueing so a same-edge beat never matches itself
            if (cmd_if.valid && cmd_if.ready) begin
                if (pending_commands.size() == 0) begin
                    error_count++;
                    if (report_count < REPORT_LIMIT) begin
                        report_count++;
                        $display("%0t: unexpected command mode %0d lin %0d ang %0d err %0d",
                                 $realtime, cmd_if.drive_mode, cmd_if.linear_speed,
                                 cmd_if.angular_speed, cmd_if.heading_error);
                    end
                end else begin
                    want = pending_commands.pop_front();
                    commands_checked++;
                    if (cmd_if.drive_mode !== want.mode || cmd_if.linear_speed !== want.lin ||
                        cmd_if.angular_speed !== want.ang ||
                        cmd_if.heading_error !== want.herr) begin
                        error_count++;
                        if (report_count < REPORT_LIMIT) begin
                            report_count++;
                            $display("%0t: command %0d expected mode %0d lin %0d ang %0d err %0d",
                                     $realtime, commands_checked, want.mode, want.lin,
                                     want.ang, want.herr);
                            $display("%0t: command %0d got      mode %0d lin %0d ang %0d err %0d",
                                     $realtime, commands_checked, cmd_if.drive_mode,
                                     cmd_if.linear_speed, cmd_if.angular_speed,
                                     cmd_if.heading_error);
                        end
                    end
                end
            end
            if (pose_if.valid && pose_if.ready) begin
                poses_accepted++;
                seen.pos_x   = pose_if.pos_x;
                seen.pos_y   = pose_if.pos_y;
                seen.heading = pose_if.heading;
                case (beat_check)
                    CHK_TYPED: pending_commands.push_back(beat_typed);
                    CHK_MODEL: if (goal_valid_q) pending_commands.push_back(predict_drive_command(seen));
                    default: ;
                endcase
            end
        end
    end

    // Stimulus
    initial begin
        t_script_row script[$];
        int          wait_cycles;
        int          leftover;

        i_rst_n         <= 1'b0;
        pose_if.valid   <= 1'b0;
        pose_if.pos_x   <= '0;
        pose_if.pos_y   <= '0;
        pose_if.heading <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= '0;
        cfg_if.data     <= '0;
        beat_check      <= CHK_NONE;
        beat_typed      <= '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed script; typed rows up to the minimum-band writes run at reset tolerances and speeds
        // no goal after reset: silent
        script.push_back(pose_row(0, 0, 0, CHK_NONE, MODE_STOP, 0, 0, 0));
        script.push_back(pose_row(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh8000,
                                  CHK_NONE, MODE_STOP, 0, 0, 0));
        // robot exactly on the goal: bearing pi, stop
        script.push_back(reg_row(REG_GOAL_VALID, 32'd1));
        script.push_back(pose_row(0, 0, 0, CHK_TYPED, MODE_STOP, 0, 0, 16'sd25736));
        // goal one metre along +x
        script.push_back(reg_row(REG_GOAL_X, 32'd65536));
        script.push_back(pose_row(0, 0, 0, CHK_TYPED, MODE_FWD, 32768, 0, 0));
        script.push_back(pose_row(131072, 0, 0, CHK_TYPED, MODE_TURN, 0, 32768, 16'sd25736));
        script.push_back(pose_row(65536, -65536, 16'sd12868, CHK_TYPED, MODE_FWD, 32768, 0, 0));
        script.push_back(pose_row(65536, 65536, -16'sd12868, CHK_TYPED, MODE_FWD, 32768, 0, 0));
        // heading extremes and the single wrap of the error
        script.push_back(pose_row(0, 0, 16'sh8000, CHK_TYPED, MODE_TURN, 0, 32768, -16'sd18704));
        script.push_back(pose_row(0, 0, 16'sh7FFF, CHK_TYPED, MODE_TURN, 0, 32768, 16'sd18705));
        script.push_back(pose_row(0, 0, 16'sd25736, CHK_TYPED, MODE_TURN, 0, 32768, 16'sd25736));
        // heading band edge, strict compare
        script.push_back(pose_row(0, 0, -16'sd819, CHK_TYPED, MODE_TURN, 0, 32768, 16'sd819));
        script.push_back(pose_row(0, 0, -16'sd818, CHK_TYPED, MODE_FWD, 32768, 0, 16'sd818));
        // arrival band edge, strict compare
        script.push_back(pose_row(58982, 0, 0, CHK_TYPED, MODE_FWD, 32768, 0, 0));
        script.push_back(pose_row(58983, 0, 0, CHK_TYPED, MODE_STOP, 0, 0, 0));
        // position extremes and bearings next to +-pi
        script.push_back(pose_row(32'sh8000_0000, 32'sh7FFF_FFFF, 0, CHK_MODEL, MODE_STOP, 0, 0, 0));
        script.push_back(pose_row(32'sh7FFF_FFFF, 32'sh8000_0000, -16'sd25736,
                                  CHK_MODEL, MODE_STOP, 0, 0, 0));
        script.push_back(pose_row(32'sh7FFF_FFFF, -1, 100, CHK_MODEL, MODE_STOP, 0, 0, 0));
        script.push_back(pose_row(32'sh7FFF_FFFF, 1, 0, CHK_MODEL, MODE_STOP, 0, 0, 0));
        script.push_back(pose_row(-1, -1, 3000, CHK_MODEL, MODE_STOP, 0, 0, 0));
        // minimum bands, extreme goal, sparse index ignored
        script.push_back(reg_row(REG_HEAD_TOL, 32'd0));
        script.push_back(reg_row(REG_ARR_TOL, 32'd0));
        script.push_back(reg_row(REG_FWD_SPEED, 32'hFFFF));
        script.push_back(reg_row(REG_TURN_SPEED, 32'd0));
        script.push_back(reg_row(REG_GOAL_X, 32'h7FFF_FFFF));
        script.push_back(reg_row(REG_GOAL_Y, 32'h8000_0000));
        script.push_back(reg_row(REG_SPARE, 32'hFFFF_FFFF));
        // on the goal facing -pi: error wraps to zero, zero band still turns
        script.push_back(pose_row(32'sh7FFF_FFFF, 32'sh8000_0000, -16'sd25736,
                                  CHK_TYPED, MODE_TURN, 0, 0, 0));
        script.push_back(pose_row(0, 0, 0, CHK_MODEL, MODE_STOP, 0, 0, 0));
        // maximum bands, upper data bits must be dropped
        script.push_back(reg_row(REG_HEAD_TOL, 32'hFFFF_7FFF));
        script.push_back(reg_row(REG_ARR_TOL, 32'hFFFF_FFFF));
        script.push_back(reg_row(REG_FWD_SPEED, 32'hFFFF_0000));
        script.push_back(reg_row(REG_TURN_SPEED, 32'h0000_FFFF));
        script.push_back(pose_row(32'sh7FFF_0000, 32'sh8000_FFFF, 0, CHK_MODEL, MODE_STOP, 0, 0, 0));
        script.push_back(pose_row(32'sh7FFF_0001, 32'sh8000_FFFE, 0, CHK_MODEL, MODE_STOP, 0, 0, 0));

        foreach (script[k]) begin
            if (script[k].kind == ROW_REG) begin
                settle_pipeline();
                write_register(script[k].index, script[k].data);
            end else begin
                offer_pose(script[k].pose, script[k].chk, script[k].cmd);
            end
        end

        // Random phases: idle mix changes, then a long receiver hold-off
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 5) begin
                // goal withdrawn: poses must pass without a command
                settle_pipeline();
                write_register(REG_GOAL_VALID, 32'hFFFF_FFFE);
                repeat (20) offer_pose(random_pose(), CHK_MODEL, '0);
            end
            load_phase_settings(phase);
            if (phase < 4) begin
                send_idle_pct = 22; recv_idle_pct = 60;
            end else if (phase < 7) begin
                send_idle_pct = 60; recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;  recv_idle_pct = 0;
            end
            if (phase == 7) stall_requests++;
            repeat (PHASE_POSES) offer_pose(random_pose(), CHK_MODEL, '0);
        end

        // Drain and close out
        pose_if.valid <= 1'b0;
        for (wait_cycles = 0; pending_commands.size() != 0 && wait_cycles < 20000; wait_cycles++)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        leftover = pending_commands.size();
        if (leftover != 0) begin
            $display("%0d expected commands never arrived", leftover);
        end

        $display("covered %0d poses, %0d commands checked, %0d register writes",
                 poses_accepted, commands_checked, register_writes);
        $display("settings swept from all-minimum to all-maximum; %0d failures",
                 error_count + leftover);
        if (error_count == 0 && leftover == 0) begin
            $display("go_to_goal_heading_controller regression: pass");
        end else begin
            $display("go_to_goal_heading_controller regression: fail");
        end
        $finish;
    end

endmodule

// File: go_to_goal_heading_controller.f
+incdir+design
design/gtg_pkg.sv
design/gtg_ifs.sv
design/gtg_norm_cell.sv
design/gtg_cordic_cell.sv
design/go_to_goal_heading_controller.sv
verif/tb_go_to_goal_heading_controller.sv
